// ===== rtl/core/dual_wheel_speed_regulator_defines.svh =====
// ----------------------------------------------------------------------------
// dual wheel speed regulator assertion macros
// shared concurrent assertion forms for the regulator rtl
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_SPEED_REGULATOR_DEFINES_SVH
`define DUAL_WHEEL_SPEED_REGULATOR_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define DWSR_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// assertion on the block clock and reset
`define DWSR_ASSERT(label, prop, msg) `DWSR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/dwsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dwsr_pkg
// widths, reset values and types shared by the speed regulator
// ----------------------------------------------------------------------------
package dwsr_pkg;

  localparam int SAMPLES_PER_AVERAGE = 6;

  localparam int CAPTURE_W  = 16;
  localparam int ELAPSED_W  = 34;
  localparam int SUM_W      = 35;
  localparam int COUNT_W    = 3;
  localparam int PWM_W      = 10;
  localparam int SETPOINT_W = 32;
  localparam int EDGE_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [ELAPSED_W-1:0] ELAPSED_MAX = 34'sh1_FFFF_FFFF;
  localparam logic signed [ELAPSED_W-1:0] WRAP_COUNTS = 34'sd65536;
  localparam logic signed [ELAPSED_W-1:0] ELAPSED_WRAP_LIMIT = ELAPSED_MAX - WRAP_COUNTS;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [PWM_W-1:0]      PWM_RESET      = 10'd800;
  localparam logic [PWM_W-1:0]      FLOOR_RESET    = 10'd100;
  localparam logic [PWM_W-1:0]      CEILING_RESET  = 10'd900;
  localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 32'd80000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_FLOOR    = 2'd1,
    CFG_CEILING  = 2'd2
  } cfg_reg_e;

  // setpoint kept as sum thresholds, so no divide is needed on the average
  typedef struct packed {
    logic [SUM_W-1:0] lo_thr;   // samples * setpoint
    logic [SUM_W-1:0] hi_thr;   // samples * (setpoint + 1)
    logic [PWM_W-1:0] pwm_floor;
    logic [PWM_W-1:0] pwm_ceiling;
  } cfg_t;

  typedef struct packed {
    logic                 timer_wrapped;
    logic                 left_edge;
    logic [CAPTURE_W-1:0] left_capture;
    logic                 right_edge;
    logic [CAPTURE_W-1:0] right_capture;
  } item_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic             adjusted;
  } wheel_res_t;

endpackage

// ===== rtl/core/dwsr_if.sv =====
// ----------------------------------------------------------------------------
// dwsr_if
// valid/ready channels of the speed regulator: events, results, config
// ----------------------------------------------------------------------------
interface dwsr_in_if import dwsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 timer_wrapped;
  logic                 left_edge;
  logic [CAPTURE_W-1:0] left_capture;
  logic                 right_edge;
  logic [CAPTURE_W-1:0] right_capture;

  modport source (
    output valid, timer_wrapped, left_edge, left_capture, right_edge, right_capture,
    input  ready
  );
  modport sink (
    input  valid, timer_wrapped, left_edge, left_capture, right_edge, right_capture,
    output ready
  );
endinterface

interface dwsr_out_if import dwsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PWM_W-1:0]  pwm_left;
  logic [PWM_W-1:0]  pwm_right;
  logic              left_adjusted;
  logic              right_adjusted;
  logic [EDGE_W-1:0] edge_count;

  modport source (
    output valid, pwm_left, pwm_right, left_adjusted, right_adjusted, edge_count,
    input  ready
  );
  modport sink (
    input  valid, pwm_left, pwm_right, left_adjusted, right_adjusted, edge_count,
    output ready
  );
endinterface

interface dwsr_cfg_if import dwsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dual_wheel_speed_regulator.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_speed_regulator
// events pass the input reg, then the result reg; a stalled result holds one more event
// in the input reg. throughput: one event per cycle while the result is not stalled
// reset: asynchronous active low; pwm 800, sums, counts and edge total zero
// ----------------------------------------------------------------------------
`include "dual_wheel_speed_regulator_defines.svh"

module dual_wheel_speed_regulator import dwsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dwsr_in_if.sink    in_i,
  dwsr_cfg_if.sink   cfg_i,
  dwsr_out_if.source out_o
);

  cfg_t              cfg;
  item_t             in_q;
  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              advance;
  logic              in_xfer;
  logic              left_adj_q, right_adj_q;
  logic [EDGE_W-1:0] edge_cnt_q, edge_cnt_d;
  wheel_res_t        left_res, right_res;

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_o.ready);
  assign edge_cnt_d  = edge_cnt_q + EDGE_W'(in_q.left_edge) + EDGE_W'(in_q.right_edge);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      edge_cnt_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) edge_cnt_q <= edge_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.timer_wrapped <= in_i.timer_wrapped;
      in_q.left_edge     <= in_i.left_edge;
      in_q.left_capture  <= in_i.left_capture;
      in_q.right_edge    <= in_i.right_edge;
      in_q.right_capture <= in_i.right_capture;
    end
    if (advance) begin
      left_adj_q  <= left_res.adjusted;
      right_adj_q <= right_res.adjusted;
    end
  end

  dwsr_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  dwsr_wheel u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .wrap_i (in_q.timer_wrapped),
    .edge_i (in_q.left_edge),
    .cap_i  (in_q.left_capture),
    .cfg_i  (cfg),
    .res_o  (left_res)
  );

  dwsr_wheel u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .wrap_i (in_q.timer_wrapped),
    .edge_i (in_q.right_edge),
    .cap_i  (in_q.right_capture),
    .cfg_i  (cfg),
    .res_o  (right_res)
  );

  // pwm and edge state only move on a transfer into the result reg
  assign out_o.valid          = out_valid_q;
  assign out_o.pwm_left       = left_res.pwm;
  assign out_o.pwm_right      = right_res.pwm;
  assign out_o.left_adjusted  = left_adj_q;
  assign out_o.right_adjusted = right_adj_q;
  assign out_o.edge_count     = edge_cnt_q;

  `DWSR_ASSERT(a_top_stall_keep, in_valid_q && out_valid_q && !out_o.ready |=> in_valid_q && $stable(in_q), "held event lost during result stall")
  `DWSR_ASSERT(a_top_adv_result, advance |=> out_valid_q, "processed event produced no result")
  `DWSR_ASSERT(a_top_edge_count, advance |=> edge_cnt_q == $past(edge_cnt_q) + EDGE_W'($past(in_q.left_edge)) + EDGE_W'($past(in_q.right_edge)), "edge total off")

endmodule

// ===== rtl/core/dwsr_cfg.sv =====
// ----------------------------------------------------------------------------
// dwsr_cfg
// configuration registers; setpoint is stored as scaled sum thresholds
// ----------------------------------------------------------------------------
module dwsr_cfg import dwsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dwsr_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  function automatic logic [SUM_W-1:0] scale_setpoint(logic [SETPOINT_W:0] v);
    return SUM_W'(SUM_W'(v) * SUM_W'(SAMPLES_PER_AVERAGE));
  endfunction

  cfg_t                  cfg_q, cfg_d;
  logic [SETPOINT_W-1:0] wr_setpoint;

  assign cfg_i.ready = 1'b1;
  assign wr_setpoint = cfg_i.data[SETPOINT_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SETPOINT: begin
          cfg_d.lo_thr = scale_setpoint({1'b0, wr_setpoint});
          cfg_d.hi_thr = scale_setpoint({1'b0, wr_setpoint} + (SETPOINT_W+1)'(1));
        end
        CFG_FLOOR:   cfg_d.pwm_floor   = cfg_i.data[PWM_W-1:0];
        CFG_CEILING: cfg_d.pwm_ceiling = cfg_i.data[PWM_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lo_thr      <= scale_setpoint({1'b0, SETPOINT_RESET});
      cfg_q.hi_thr      <= scale_setpoint({1'b0, SETPOINT_RESET} + (SETPOINT_W+1)'(1));
      cfg_q.pwm_floor   <= FLOOR_RESET;
      cfg_q.pwm_ceiling <= CEILING_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/dwsr_wheel.sv =====
// ----------------------------------------------------------------------------
// dwsr_wheel
// per-wheel edge period tracking, period averaging and pwm stepping
// ----------------------------------------------------------------------------
`include "dual_wheel_speed_regulator_defines.svh"

module dwsr_wheel import dwsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 wrap_i,
  input  logic                 edge_i,
  input  logic [CAPTURE_W-1:0] cap_i,
  input  cfg_t                 cfg_i,
  output wheel_res_t           res_o
);

  logic signed [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_w;
  logic [ELAPSED_W:0]          period;
  logic [ELAPSED_W-1:0]        period_clamped;
  logic [SUM_W:0]              sum_ext;
  logic [SUM_W-1:0]            sum_q, sum_d, sum_sat;
  logic [COUNT_W-1:0]          count_q, count_d, count_inc;
  logic [PWM_W-1:0]            pwm_q, pwm_d;
  logic                        hit;

  always_comb begin
    elapsed_w = elapsed_q;
    if (wrap_i) begin
      if (elapsed_q > ELAPSED_WRAP_LIMIT) begin
        elapsed_w = ELAPSED_MAX;
      end else begin
        elapsed_w = elapsed_q + WRAP_COUNTS;
      end
    end

    // sign-extended elapsed plus zero-extended capture
    period         = {elapsed_w[ELAPSED_W-1], elapsed_w} + (ELAPSED_W+1)'(cap_i);
    period_clamped = period[ELAPSED_W] ? '0 : period[ELAPSED_W-1:0];
    sum_ext        = {1'b0, sum_q} + (SUM_W+1)'(period_clamped);
    sum_sat        = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    count_inc      = count_q + COUNT_W'(1);
    hit            = edge_i && (count_inc == COUNT_W'(SAMPLES_PER_AVERAGE));

    elapsed_d = elapsed_w;
    sum_d     = sum_q;
    count_d   = count_q;
    pwm_d     = pwm_q;
    if (edge_i) begin
      elapsed_d = -$signed(ELAPSED_W'(cap_i));
      sum_d     = sum_sat;
      count_d   = count_inc;
      if (hit) begin
        // avg > setpoint  <=>  sum >= n * (setpoint + 1)
        priority if (sum_sat >= cfg_i.hi_thr) begin
          if (pwm_q > cfg_i.pwm_floor) pwm_d = pwm_q - PWM_W'(1);
        end else if (sum_sat < cfg_i.lo_thr) begin
          if (pwm_q < cfg_i.pwm_ceiling) pwm_d = pwm_q + PWM_W'(1);
        end
        sum_d   = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      pwm_q     <= PWM_RESET;
    end else if (step_i) begin
      elapsed_q <= elapsed_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      pwm_q     <= pwm_d;
    end
  end

  assign res_o.pwm      = pwm_q;
  assign res_o.adjusted = hit;

  `DWSR_ASSERT(a_wheel_hold, !step_i |=> $stable(sum_q) && $stable(count_q) && $stable(pwm_q), "wheel state changed with no transfer")
  `DWSR_ASSERT(a_wheel_pwm_step, step_i |=> (pwm_q == $past(pwm_q)) || (pwm_q == $past(pwm_q) + PWM_W'(1)) || (pwm_q == $past(pwm_q) - PWM_W'(1)), "pwm moved by more than one step")
  `DWSR_ASSERT(a_wheel_avg_clear, step_i && hit |=> (sum_q == '0) && (count_q == '0), "period sum not cleared after average")

endmodule
